FILE: sv/clcd_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD sequencer package
// Shared payload types, request codes, command table and the control
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package clcd_pkg;

   // Highest cursor column accepted by a set cursor request.
   localparam int MAX_COLUMN = 15;

   // Request codes.
   localparam logic [2:0] REQ_INIT        = 3'd0;
   localparam logic [2:0] REQ_CLEAR       = 3'd1;
   localparam logic [2:0] REQ_HOME        = 3'd2;
   localparam logic [2:0] REQ_SET_CURSOR  = 3'd3;
   localparam logic [2:0] REQ_WRITE_CHAR  = 3'd4;
   localparam logic [2:0] REQ_DISPLAY_ON  = 3'd5;
   localparam logic [2:0] REQ_DISPLAY_OFF = 3'd6;

   // Kinds of step in a request's command list.
   localparam logic [1:0] OP_PAUSE  = 2'd0;
   localparam logic [1:0] OP_NIBBLE = 2'd1;
   localparam logic [1:0] OP_BYTE   = 2'd2;
   localparam logic [1:0] OP_ERROR  = 2'd3;

   // LCD command bytes.
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_HOME         = 8'h02;
   localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
   localparam logic [7:0] LCD_ROW1_OFFSET  = 8'h40;
   localparam logic [3:0] LCD_WAKE_NIBBLE  = 4'h3;
   localparam logic [3:0] LCD_4BIT_NIBBLE  = 4'h2;

   // Waits in microseconds.
   localparam logic [14:0] WAIT_POWER_UP = 15'd30000;
   localparam logic [14:0] WAIT_WAKE     = 15'd5000;
   localparam logic [14:0] WAIT_LONG     = 15'd2000;
   localparam logic [14:0] WAIT_SHORT    = 15'd100;
   localparam logic [14:0] WAIT_NONE     = 15'd0;

   // Last step index of the init command list.
   localparam logic [3:0] INIT_LAST_STEP = 4'd9;

   typedef struct packed {
      logic [2:0] req_type;
      logic [1:0] row;
      logic [4:0] col;
      logic [7:0] char_code;
   } clcd_req_type;

   typedef struct packed {
      logic [7:0]  expander_byte;
      logic        write_valid;
      logic [14:0] wait_us;
      logic        error;
      logic        last;
   } clcd_rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        rs;
      logic [14:0] wait_us;
      logic        last_op;
   } clcd_op_type;

   typedef struct packed {
      logic load;
      logic advance;
   } clcd_cmd_type;

   typedef struct packed {
      logic unknown_req;
      logic last;
   } clcd_status_type;

   // Step number idx of the command list for a request.
   function automatic clcd_op_type clcd_op(input clcd_req_type req, input logic [3:0] idx);
      clcd_op_type op;
      logic [7:0]  addr;
      op      = '{kind: OP_ERROR, data: 8'h00, rs: 1'b0, wait_us: WAIT_NONE, last_op: 1'b1};
      addr    = LCD_SET_DDRAM | ((req.row[0] ? LCD_ROW1_OFFSET : 8'h00) + 8'(req.col));
      unique case (req.req_type)
         REQ_INIT: begin
            op.last_op = (idx == INIT_LAST_STEP);
            op.wait_us = WAIT_SHORT;
            unique case (idx)
               4'd0: begin
                  op.kind    = OP_PAUSE;
                  op.wait_us = WAIT_POWER_UP;
               end
               4'd1: begin
                  op.kind    = OP_NIBBLE;
                  op.data    = {4'h0, LCD_WAKE_NIBBLE};
                  op.wait_us = WAIT_WAKE;
               end
               4'd2, 4'd3: begin
                  op.kind = OP_NIBBLE;
                  op.data = {4'h0, LCD_WAKE_NIBBLE};
               end
               4'd4: begin
                  op.kind = OP_NIBBLE;
                  op.data = {4'h0, LCD_4BIT_NIBBLE};
               end
               4'd5: begin
                  op.kind = OP_BYTE;
                  op.data = LCD_FUNCTION_SET;
               end
               4'd6: begin
                  op.kind = OP_BYTE;
                  op.data = CMD_DISPLAY_ON;
               end
               4'd7: begin
                  op.kind    = OP_BYTE;
                  op.data    = CMD_CLEAR;
                  op.wait_us = WAIT_LONG;
               end
               4'd8: begin
                  op.kind = OP_BYTE;
                  op.data = LCD_ENTRY_MODE;
               end
               default: begin
                  op.kind = OP_BYTE;
                  op.data = LCD_SET_DDRAM;
               end
            endcase
         end
         REQ_CLEAR: begin
            op.kind    = OP_BYTE;
            op.data    = CMD_CLEAR;
            op.wait_us = WAIT_LONG;
         end
         REQ_HOME: begin
            op.kind    = OP_BYTE;
            op.data    = CMD_HOME;
            op.wait_us = WAIT_LONG;
         end
         REQ_SET_CURSOR: begin
            if (!(req.row[1] || (32'(req.col) > MAX_COLUMN))) begin
               op.kind    = OP_BYTE;
               op.data    = addr;
               op.wait_us = WAIT_SHORT;
            end
         end
         REQ_WRITE_CHAR: begin
            op.kind    = OP_BYTE;
            op.data    = req.char_code;
            op.rs      = 1'b1;
            op.wait_us = WAIT_SHORT;
         end
         REQ_DISPLAY_ON: begin
            op.kind    = OP_BYTE;
            op.data    = CMD_DISPLAY_ON;
            op.wait_us = WAIT_SHORT;
         end
         REQ_DISPLAY_OFF: begin
            op.kind    = OP_BYTE;
            op.data    = CMD_DISPLAY_OFF;
            op.wait_us = WAIT_SHORT;
         end
         default: begin
            op.kind = OP_ERROR;
         end
      endcase
      return op;
   endfunction

endpackage

FILE: sv/clcd_datapath.sv
// ----------------------------------------------------------------------------
// Character LCD sequencer datapath
// Holds the request, walks its command list one beat at a time and
// frames each nibble write into the registered result.
// ----------------------------------------------------------------------------
module clcd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  clcd_pkg::clcd_req_type   req_data,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data,
   input  clcd_pkg::clcd_cmd_type   cmd,
   output clcd_pkg::clcd_status_type status,
   output clcd_pkg::clcd_rsp_type   rsp_data
);
   import clcd_pkg::*;

   // Position in the command list: step, nibble half and write phase.
   typedef struct packed {
      logic [3:0] idx;
      logic       half;
      logic [1:0] phase;
   } clcd_pos_type;

   localparam logic [1:0] PHASE_STROBE = 2'd1;
   localparam logic [1:0] PHASE_LAST   = 2'd2;

   logic         backlight_ff, backlight_in;
   clcd_req_type req_ff, req_in;
   clcd_pos_type pos_ff, pos_in, next_pos;
   clcd_rsp_type rsp_ff, rsp_in;
   clcd_op_type  cur_op, sel_op;
   logic         cur_done, sel_done;
   logic [3:0]   nib;

   always_comb begin
      backlight_in = csr_wr_en ? csr_wr_data : backlight_ff;

      cur_op   = clcd_op(req_ff, pos_ff.idx);
      cur_done = (cur_op.kind == OP_PAUSE) || (cur_op.kind == OP_ERROR) ||
                 ((pos_ff.phase == PHASE_LAST) && ((cur_op.kind == OP_NIBBLE) || pos_ff.half));
      next_pos = pos_ff;
      if (cur_done) begin
         next_pos.idx   = pos_ff.idx + 4'd1;
         next_pos.half  = 1'b0;
         next_pos.phase = 2'd0;
      end else if (pos_ff.phase == PHASE_LAST) begin
         next_pos.half  = 1'b1;
         next_pos.phase = 2'd0;
      end else begin
         next_pos.phase = pos_ff.phase + 2'd1;
      end

      if (cmd.load) begin
         req_in = req_data;
         pos_in = '0;
      end else begin
         req_in = req_ff;
         pos_in = next_pos;
      end

      sel_op   = clcd_op(req_in, pos_in.idx);
      sel_done = (pos_in.phase == PHASE_LAST) && ((sel_op.kind == OP_NIBBLE) || pos_in.half);
      nib      = ((sel_op.kind == OP_BYTE) && !pos_in.half) ? sel_op.data[7:4] : sel_op.data[3:0];

      rsp_in = '{expander_byte: 8'h00, write_valid: 1'b0, wait_us: WAIT_NONE,
                 error: 1'b0, last: sel_op.last_op};
      case (sel_op.kind)
         OP_PAUSE: begin
            rsp_in.wait_us = sel_op.wait_us;
         end
         OP_ERROR: begin
            rsp_in.error = 1'b1;
         end
         default: begin
            rsp_in.expander_byte = {nib, backlight_ff, (pos_in.phase == PHASE_STROBE),
                                    1'b0, sel_op.rs};
            rsp_in.write_valid   = 1'b1;
            rsp_in.wait_us       = sel_done ? sel_op.wait_us : WAIT_NONE;
            rsp_in.last          = sel_done && sel_op.last_op;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff <= 1'b1;
      end else begin
         backlight_ff <= backlight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.advance) begin
         req_ff <= req_in;
         pos_ff <= pos_in;
         rsp_ff <= rsp_in;
      end
   end

   assign status.unknown_req = (req_data.req_type > REQ_DISPLAY_OFF);
   assign status.last        = rsp_ff.last;
   assign rsp_data           = rsp_ff;

endmodule

FILE: sv/clcd_controller.sv
// ----------------------------------------------------------------------------
// Character LCD sequencer controller
// Two-state machine that takes a request, then issues one beat per
// accepted result until the final one of the run is taken.
// ----------------------------------------------------------------------------
module clcd_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  clcd_pkg::clcd_status_type status,
   output clcd_pkg::clcd_cmd_type    cmd
);
   import clcd_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // An unknown request is taken and dropped without results.
            if (req_valid && !status.unknown_req) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/char_lcd_expander_sequencer_top.sv
// ----------------------------------------------------------------------------
// Character LCD expander sequencer, top level
// Expands each LCD request into the run of port expander bytes that drives
// a 4-bit character LCD, one result beat per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  req_data  (clcd_req_type)
//   rsp_      out        rsp_valid/rsp_ready  rsp_data  (clcd_rsp_type)
//   csr_      in         csr_wr_en            csr_wr_data (backlight on)
//
// A request is taken only while the block is idle; its results then follow
// one beat per cycle while the result side does not stall, and the next
// request is taken only after the last beat. Init yields 43 results; the
// other requests yield 6 results (one for a rejected cursor). A single
// registered result stage holds each beat, and the command-list sequencer
// refills it once per accepted beat.
// Reset is synchronous and active high; it returns the controller to idle
// and turns the backlight bit on. A low rsp_ready holds the current beat.
//
module char_lcd_expander_sequencer_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  clcd_pkg::clcd_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output clcd_pkg::clcd_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);
   import clcd_pkg::*;

   // Commands from the controller and status back from the datapath.
   clcd_cmd_type    cmd;
   clcd_status_type status;

   // The controller decides when a request is taken and when a beat is
   // handed over; it never looks at the payload itself.
   clcd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the request, steps through its command list and
   // keeps the result beat registered until it is taken.
   clcd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: dv/tb_char_lcd_expander_sequencer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD expander sequencer testbench
// Drives LCD requests through the request channel and compares every
// expander beat on the result channel, field by field, against a behavioral
// predictor kept in this file. The run opens with a directed table. Random
// phases follow at both backlight settings. Both channels idle at random,
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_char_lcd_expander_sequencer_top;
   import clcd_pkg::*;

   // Request code outside the defined set; the block drops it silently.
   localparam logic [2:0] REQ_UNKNOWN     = 3'd7;
   // Expander bit that pulses the LCD enable line.
   localparam logic [7:0] EXP_ENABLE      = 8'h04;

   localparam int         CLOCK_HALF      = 4;
   localparam int         RESET_CYCLES    = 7;
   // An init run is the longest one. This margin covers it plus a request
   // that gives no beat at all.
   localparam int         DRAIN_CYCLES    = 64;
   // Longest stretch without any handshake before the run is declared hung.
   localparam int         STALL_LIMIT     = 4000;
   localparam int         HOLD_AFTER_REQS = 80;
   localparam int         HOLD_CYCLES     = 300;
   localparam int         BATCH_REQS      = 98;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_TOGGLE} ready_mode_type;

   // One row of the directed table. A row with a typed result expects exactly
   // that single beat. Every other row is checked through the predictor.
   typedef struct packed {
      clcd_req_type req;
      logic         typed;
      clcd_rsp_type typed_rsp;
   } lcd_row_type;

   localparam clcd_rsp_type NO_RSP  = '0;
   localparam clcd_rsp_type ERR_RSP = '{expander_byte: 8'h00, write_valid: 1'b0,
                                        wait_us: WAIT_NONE, error: 1'b1, last: 1'b1};

   localparam int DIRECTED_ROWS = 23;
   localparam lcd_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Init straight out of reset, with the backlight at its reset value.
      '{'{REQ_INIT,        2'd0, 5'd0,  8'h00}, 1'b0, NO_RSP},
      // Fields that the request does not use are set to all ones.
      '{'{REQ_CLEAR,       2'd3, 5'd31, 8'hFF}, 1'b0, NO_RSP},
      '{'{REQ_HOME,        2'd0, 5'd0,  8'h00}, 1'b0, NO_RSP},
      // Cursor positions that are still in range, the four corners among them.
      '{'{REQ_SET_CURSOR,  2'd0, 5'd0,  8'h00}, 1'b0, NO_RSP},
      '{'{REQ_SET_CURSOR,  2'd1, 5'd15, 8'hFF}, 1'b0, NO_RSP},
      '{'{REQ_SET_CURSOR,  2'd0, 5'd15, 8'h00}, 1'b0, NO_RSP},
      '{'{REQ_SET_CURSOR,  2'd1, 5'd0,  8'h00}, 1'b0, NO_RSP},
      '{'{REQ_SET_CURSOR,  2'd1, 5'd7,  8'hAA}, 1'b0, NO_RSP},
      // A rejected cursor gives one error beat.
      '{'{REQ_SET_CURSOR,  2'd2, 5'd0,  8'h00}, 1'b1, ERR_RSP},
      '{'{REQ_SET_CURSOR,  2'd3, 5'd31, 8'hFF}, 1'b1, ERR_RSP},
      '{'{REQ_SET_CURSOR,  2'd0, 5'd16, 8'h00}, 1'b1, ERR_RSP},
      '{'{REQ_SET_CURSOR,  2'd1, 5'd31, 8'h00}, 1'b1, ERR_RSP},
      '{'{REQ_SET_CURSOR,  2'd3, 5'd0,  8'h00}, 1'b1, ERR_RSP},
      '{'{REQ_WRITE_CHAR,  2'd0, 5'd0,  8'h00}, 1'b0, NO_RSP},
      '{'{REQ_WRITE_CHAR,  2'd3, 5'd31, 8'hFF}, 1'b0, NO_RSP},
      '{'{REQ_WRITE_CHAR,  2'd1, 5'd10, 8'hA5}, 1'b0, NO_RSP},
      '{'{REQ_WRITE_CHAR,  2'd2, 5'd21, 8'h5A}, 1'b0, NO_RSP},
      '{'{REQ_DISPLAY_ON,  2'd0, 5'd0,  8'h00}, 1'b0, NO_RSP},
      '{'{REQ_DISPLAY_OFF, 2'd3, 5'd31, 8'hFF}, 1'b0, NO_RSP},
      // Unknown codes are dropped. The next request must still come out right.
      '{'{REQ_UNKNOWN,     2'd3, 5'd31, 8'hFF}, 1'b0, NO_RSP},
      '{'{REQ_UNKNOWN,     2'd0, 5'd0,  8'h00}, 1'b0, NO_RSP},
      '{'{REQ_INIT,        2'd1, 5'd21, 8'h3C}, 1'b0, NO_RSP},
      '{'{REQ_WRITE_CHAR,  2'd0, 5'd3,  8'h80}, 1'b0, NO_RSP}
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   clcd_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   clcd_rsp_type rsp_data;
   logic         csr_wr_en;
   logic         csr_wr_data;

   // Predictor state: the backlight register as the block should hold it,
   // and the beats still owed, oldest first.
   logic         bl_model;
   clcd_rsp_type lcd_beats_due[$];

   // The driver publishes these before it offers a row. The monitor reads
   // them on the edge where the request is taken.
   logic         row_typed;
   clcd_rsp_type row_typed_rsp;

   int           reqs_taken;
   int           mismatch_count;
   int           quiet_cycles;
   int           burst_left;

   char_lcd_expander_sequencer_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic void push_beat(input logic [7:0] b, input logic v,
                                     input logic [14:0] w, input logic e);
      clcd_rsp_type t;
      t.expander_byte = b;
      t.write_valid   = v;
      t.wait_us       = w;
      t.error         = e;
      t.last          = 1'b0;
      lcd_beats_due.push_back(t);
   endfunction

   // Each nibble goes out three times: plain, with enable high, then plain
   // again. Only the last of the three carries the wait.
   function automatic void push_nibble(input logic [3:0] nib, input logic rs,
                                       input logic [14:0] w);
      logic [7:0] d;
      d = {nib, bl_model, 2'b00, rs};
      push_beat(d, 1'b1, WAIT_NONE, 1'b0);
      push_beat(d | EXP_ENABLE, 1'b1, WAIT_NONE, 1'b0);
      push_beat(d, 1'b1, w, 1'b0);
   endfunction

   function automatic void push_lcd_byte(input logic [7:0] b, input logic rs,
                                         input logic [14:0] w);
      push_nibble(b[7:4], rs, WAIT_NONE);
      push_nibble(b[3:0], rs, w);
   endfunction

   // Appends the beats that one accepted request should produce. The final
   // beat of the run is then flagged as last.
   function automatic void predict_lcd_run(input clcd_req_type r);
      int start_size;
      start_size = lcd_beats_due.size();
      case (r.req_type)
         REQ_INIT: begin
            push_beat(8'h00, 1'b0, WAIT_POWER_UP, 1'b0);
            push_nibble(LCD_WAKE_NIBBLE, 1'b0, WAIT_WAKE);
            push_nibble(LCD_WAKE_NIBBLE, 1'b0, WAIT_SHORT);
            push_nibble(LCD_WAKE_NIBBLE, 1'b0, WAIT_SHORT);
            push_nibble(LCD_4BIT_NIBBLE, 1'b0, WAIT_SHORT);
            push_lcd_byte(LCD_FUNCTION_SET, 1'b0, WAIT_SHORT);
            push_lcd_byte(CMD_DISPLAY_ON, 1'b0, WAIT_SHORT);
            push_lcd_byte(CMD_CLEAR, 1'b0, WAIT_LONG);
            push_lcd_byte(LCD_ENTRY_MODE, 1'b0, WAIT_SHORT);
            push_lcd_byte(LCD_SET_DDRAM, 1'b0, WAIT_SHORT);
         end
         REQ_CLEAR:       push_lcd_byte(CMD_CLEAR, 1'b0, WAIT_LONG);
         REQ_HOME:        push_lcd_byte(CMD_HOME, 1'b0, WAIT_LONG);
         REQ_SET_CURSOR: begin
            if (r.row > 2'd1 || r.col > MAX_COLUMN) begin
               push_beat(8'h00, 1'b0, WAIT_NONE, 1'b1);
            end else begin
               push_lcd_byte(LCD_SET_DDRAM |
                             ((r.row[0] ? LCD_ROW1_OFFSET : 8'h00) + {3'b000, r.col}),
                             1'b0, WAIT_SHORT);
            end
         end
         REQ_WRITE_CHAR:  push_lcd_byte(r.char_code, 1'b1, WAIT_SHORT);
         REQ_DISPLAY_ON:  push_lcd_byte(CMD_DISPLAY_ON, 1'b0, WAIT_SHORT);
         REQ_DISPLAY_OFF: push_lcd_byte(CMD_DISPLAY_OFF, 1'b0, WAIT_SHORT);
         default: begin
         end
      endcase
      if (lcd_beats_due.size() > start_size) begin
         lcd_beats_due[lcd_beats_due.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic void check_field(input string name, input logic [14:0] want,
                                       input logic [14:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor. Everything that happens on one rising edge is handled here, in
   // a fixed order. A backlight write comes first, then a request taken,
   // then a beat delivered. A request and a beat on the same edge therefore
   // never race on the queue.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_beats
      clcd_rsp_type want;
      if (reset) begin
         bl_model = 1'b1;
      end else begin
         if (csr_wr_en) begin
            bl_model = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            reqs_taken++;
            if (row_typed) begin
               lcd_beats_due.push_back(row_typed_rsp);
            end else begin
               predict_lcd_run(req_data);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (lcd_beats_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: beat with nothing expected, expected none, got %h",
                        $time, rsp_data);
            end else begin
               want = lcd_beats_due.pop_front();
               check_field("expander_byte", 15'(want.expander_byte), 15'(rsp_data.expander_byte));
               check_field("write_valid", 15'(want.write_valid), 15'(rsp_data.write_valid));
               check_field("wait_us", want.wait_us, rsp_data.wait_us);
               check_field("error", 15'(want.error), 15'(rsp_data.error));
               check_field("last", 15'(want.last), 15'(rsp_data.last));
            end
         end
      end
   end

   // The watchdog trips if neither channel moves a beat for too long. The
   // longest legal quiet stretch is the long hold on the result side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Result side. Ready follows a random mode that changes at random
   // times. The modes are always ready, coin flip, mostly stalled and
   // strict toggling. Once enough requests have gone in, ready drops for a
   // long stretch while the sender keeps offering. The block then fills up
   // and must push back on its input.
   // ------------------------------------------------------------------------
   initial begin : drive_ready
      ready_mode_type mode;
      int             mode_left;
      int             hold_left;
      bit             hold_done;
      mode      = READY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && reqs_taken >= HOLD_AFTER_REQS) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               READY_ALWAYS: rsp_ready <= 1'b1;
               READY_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
               default:      rsp_ready <= ~rsp_ready;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Holds one request on the channel until it is taken. The task is entered
   // at a falling edge and returns at the falling edge after acceptance.
   task automatic offer_req(input clcd_req_type r, input logic typed,
                            input clcd_rsp_type trsp);
      row_typed     = typed;
      row_typed_rsp = trsp;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Requests go out in bursts of random length. A burst is followed by a
   // random gap, and now and then by none, so that bursts run together.
   // Valid drops only when a gap really follows. It is never lowered and
   // raised again on the same edge.
   task automatic pace_sender();
      int gap;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Mostly well-formed traffic with random payloads. Init is kept rare
   // because it is long. A small share are cursor moves with any position,
   // often out of range, and unknown codes.
   function automatic clcd_req_type random_req();
      clcd_req_type r;
      int           pick;
      r.row       = 2'($urandom_range(0, 3));
      r.col       = 5'($urandom_range(0, 31));
      r.char_code = 8'($urandom_range(0, 255));
      pick        = $urandom_range(0, 99);
      if (pick < 6) begin
         r.req_type = REQ_INIT;
      end else if (pick < 92) begin
         r.req_type = 3'($urandom_range(REQ_CLEAR, REQ_DISPLAY_OFF));
         if (r.req_type == REQ_SET_CURSOR) begin
            r.row = 2'($urandom_range(0, 1));
            r.col = 5'($urandom_range(0, MAX_COLUMN));
         end
      end else if (pick < 97) begin
         r.req_type = REQ_SET_CURSOR;
      end else begin
         r.req_type = REQ_UNKNOWN;
      end
      return r;
   endfunction

   // Dropped requests do not count toward the batch size.
   task automatic random_batch(input int n);
      clcd_req_type r;
      int           sent;
      sent = 0;
      while (sent < n) begin
         r = random_req();
         offer_req(r, 1'b0, NO_RSP);
         if (r.req_type != REQ_UNKNOWN) begin
            sent++;
         end
         pace_sender();
      end
   endtask

   // Lets every owed beat arrive. It then waits long enough for a dropped
   // request still inside the block to retire.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (lcd_beats_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_backlight(input logic v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence. Reset comes first, then the directed table at the
   // backlight reset value. Four random phases follow, and the backlight is
   // rewritten between them while the block is idle. The run goes through
   // both settings twice.
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      int i;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = 1'b0;
      row_typed      = 1'b0;
      row_typed_rsp  = NO_RSP;
      reqs_taken     = 0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      burst_left     = 0;
      bl_model       = 1'b1;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         offer_req(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].typed_rsp);
         pace_sender();
      end
      wait_idle();

      write_backlight(1'b0);
      random_batch(BATCH_REQS);
      wait_idle();
      write_backlight(1'b1);
      random_batch(BATCH_REQS);
      wait_idle();
      write_backlight(1'b0);
      random_batch(BATCH_REQS);
      wait_idle();
      write_backlight(1'b1);
      random_batch(BATCH_REQS);
      wait_idle();

      if (mismatch_count == 0 && lcd_beats_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
